// ----- rtl/core/vmht_pkg.sv -----
// Shared types and codes for the value multiplicity hash table.
package vmht_pkg;

    typedef enum logic [2:0] {
        OUT_UNIQUE    = 3'd0,
        OUT_BECAME    = 3'd1,
        OUT_REPEAT    = 3'd2,
        OUT_FULL      = 3'd3,
        OUT_CLEARED   = 3'd4
    } outcome_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] item_value;
        logic [15:0] item_id;
    } item_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [7:0]  bucket_index;
        logic [15:0] partner_id;
        logic [15:0] multiplicity;
        logic [31:0] bucket_sum;
        logic [31:0] grand_sum;
    } result_t;

    localparam logic KIND_ENTER = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture item, start modulo
        logic mod_step;   // one restoring-division step
        logic clr_step;   // clear one bucket
        logic rd;         // issue slot/bucket read
        logic scan;       // evaluate read slot
        logic commit;     // write back and build result
        logic clr_done;   // build cleared result
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic mod_last;
        logic scan_last;
        logic clr_last;
    } stat_t;

endpackage

// ----- rtl/core/vmht_ctrl.sv -----
// Sequencing state machine for the hash table.
module vmht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vmht_pkg::stat_t   stat,
    output vmht_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MOD   = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_WB    = 7'b0010000,
        ST_CLR   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (stat.is_clear)
                    state_next = ST_CLR;
                else
                begin
                    cmd.mod_step = 1'b1;
                    if (stat.mod_last)
                        state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                state_next = stat.scan_last ? ST_WB : ST_RD;
            end
            ST_WB:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.clr_done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_MOD)
        else $error("start not taken");
    a_wb_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WB |=> state_reg == ST_IDLE)
        else $error("write-back not final");

endmodule

// ----- rtl/core/vmht_dp.sv -----
// Datapath: modulo unit, slot store, bucket sums and result register.
module vmht_dp #(
    parameter int MAX_BUCKETS      = 256,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vmht_pkg::item_t   item,
    input  logic [8:0]        hash_size,
    input  vmht_pkg::cmd_t    cmd,
    output vmht_pkg::stat_t   stat,
    output logic              done,
    output vmht_pkg::result_t result
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int TOTAL = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW = $clog2(TOTAL);
    localparam int DW = (BW > 9) ? BW : 9;

    // slot memories
    logic [31:0] val_mem [TOTAL];
    logic [15:0] own_mem [TOTAL];
    logic [15:0] cnt_mem [TOTAL];
    logic [31:0] sum_mem [MAX_BUCKETS];
    logic [SW:0] fill_mem [MAX_BUCKETS];   // used slots per bucket, always a prefix
    logic [MAX_BUCKETS-1:0] cnt_ok_reg;  // bucket's fill and sum valid since clear

    logic        kind_reg;
    logic [31:0] value_reg;
    logic [15:0] id_reg;
    logic [DW-1:0] div_reg;
    logic [DW-1:0] rem_reg;
    logic [5:0]  step_reg;
    logic [BW-1:0] clr_reg;
    logic [SW:0] idx_reg;
    logic [31:0] rd_val_reg;
    logic [15:0] rd_own_reg;
    logic [15:0] rd_cnt_reg;
    logic [31:0] rd_sum_reg;
    logic [SW:0] rd_fill_reg;
    logic        rd_ok_reg;
    logic        found_reg, have_free_reg;
    logic [SW-1:0] hit_reg, free_reg;
    logic [15:0] hit_cnt_reg, hit_own_reg;
    logic [31:0] grand_reg;
    logic        done_reg;
    vmht_pkg::result_t result_reg;

    logic [DW-1:0] nb;
    logic [DW:0]   trial;
    logic [BW-1:0] bucket;
    logic [AW-1:0] rd_addr, hit_addr, free_addr;
    logic [SW:0]   slot_idx;
    logic [31:0]   cur_sum;
    logic          slot_used;

    always_comb
    begin
        nb = DW'(hash_size);
        if (hash_size == 9'd0)
            nb = DW'(1);
        else if (32'(hash_size) > 32'(MAX_BUCKETS))
            nb = DW'(MAX_BUCKETS);
    end

    assign trial = {rem_reg, value_reg[31 - step_reg[4:0]]} - {1'b0, div_reg};
    assign bucket = rem_reg[BW-1:0];
    assign rd_addr = AW'(32'(bucket) * SLOTS_PER_BUCKET + 32'(idx_reg[SW-1:0]));
    assign hit_addr = AW'(32'(bucket) * SLOTS_PER_BUCKET + 32'(hit_reg));
    assign free_addr = AW'(32'(bucket) * SLOTS_PER_BUCKET + 32'(free_reg));
    assign slot_idx = idx_reg - 1'b1;
    // a bucket untouched since clear has no used slots and a zero sum
    assign slot_used = rd_ok_reg && (slot_idx < rd_fill_reg);
    assign cur_sum = rd_ok_reg ? rd_sum_reg : 32'd0;

    assign stat.is_clear = kind_reg;
    assign stat.mod_last = (step_reg == 6'd31);
    assign stat.scan_last = (32'(idx_reg) == 32'(SLOTS_PER_BUCKET));
    assign stat.clr_last = (32'(clr_reg) == 32'(MAX_BUCKETS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_val_reg <= val_mem[rd_addr];
            rd_own_reg <= own_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
            rd_sum_reg <= sum_mem[bucket];
            rd_fill_reg <= fill_mem[bucket];
            rd_ok_reg <= cnt_ok_reg[bucket];
        end
        if (cmd.commit)
        begin
            if (found_reg)
            begin
                if (hit_cnt_reg == 16'd1)
                    cnt_mem[hit_addr] <= 16'd2;
                else if (hit_cnt_reg != vmht_pkg::COUNT_MAX)
                    cnt_mem[hit_addr] <= hit_cnt_reg + 16'd1;
            end
            else if (have_free_reg)
            begin
                val_mem[free_addr] <= value_reg;
                own_mem[free_addr] <= id_reg;
                cnt_mem[free_addr] <= 16'd1;
                fill_mem[bucket] <= rd_ok_reg ? rd_fill_reg + 1'b1 : {{SW{1'b0}}, 1'b1};
            end
        end
        // first insert into a bucket since clear starts its sum at zero
        if (cmd.clr_step)
            sum_mem[clr_reg] <= 32'd0;
        else if (cmd.commit && found_reg)
            sum_mem[bucket] <= rd_sum_reg + ((hit_cnt_reg == 16'd1) ?
                                {value_reg[30:0], 1'b0} : value_reg);
        else if (cmd.commit && have_free_reg && !rd_ok_reg)
            sum_mem[bucket] <= 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            grand_reg <= 32'd0;
            cnt_ok_reg <= '0;
            step_reg <= '0;
            idx_reg <= '0;
            clr_reg <= '0;
            kind_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit || cmd.clr_done;
            if (cmd.load)
            begin
                kind_reg <= item.kind;
                value_reg <= item.item_value;
                id_reg <= item.item_id;
                div_reg <= nb;
                rem_reg <= '0;
                step_reg <= '0;
                idx_reg <= '0;
                clr_reg <= '0;
                found_reg <= 1'b0;
                have_free_reg <= 1'b0;
            end
            if (cmd.mod_step)
            begin
                if (!trial[DW])
                    rem_reg <= trial[DW-1:0];
                else
                    rem_reg <= {rem_reg[DW-2:0], value_reg[31 - step_reg[4:0]]};
                step_reg <= step_reg + 6'd1;
            end
            if (cmd.rd)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.scan)
            begin
                if (slot_used)
                begin
                    if (!found_reg && rd_val_reg == value_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg <= SW'(idx_reg - 1'b1);
                        hit_cnt_reg <= rd_cnt_reg;
                        hit_own_reg <= rd_own_reg;
                    end
                end
                else if (!have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                    free_reg <= SW'(idx_reg - 1'b1);
                end
            end
            if (cmd.clr_step)
            begin
                cnt_ok_reg <= '0;
                grand_reg <= 32'd0;
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                result_reg.bucket_index <= 8'(bucket);
                if (found_reg)
                begin
                    result_reg.outcome <= (hit_cnt_reg == 16'd1) ?
                        vmht_pkg::OUT_BECAME : vmht_pkg::OUT_REPEAT;
                    result_reg.partner_id <= hit_own_reg;
                    result_reg.multiplicity <= (hit_cnt_reg == 16'd1) ? 16'd2 :
                        ((hit_cnt_reg == vmht_pkg::COUNT_MAX) ? hit_cnt_reg :
                         hit_cnt_reg + 16'd1);
                    result_reg.bucket_sum <= rd_sum_reg + ((hit_cnt_reg == 16'd1) ?
                        {value_reg[30:0], 1'b0} : value_reg);
                    result_reg.grand_sum <= grand_reg + ((hit_cnt_reg == 16'd1) ?
                        {value_reg[30:0], 1'b0} : value_reg);
                    grand_reg <= grand_reg + ((hit_cnt_reg == 16'd1) ?
                        {value_reg[30:0], 1'b0} : value_reg);
                end
                else
                begin
                    result_reg.outcome <= have_free_reg ? vmht_pkg::OUT_UNIQUE :
                        vmht_pkg::OUT_FULL;
                    result_reg.partner_id <= have_free_reg ? id_reg : 16'd0;
                    result_reg.multiplicity <= have_free_reg ? 16'd1 : 16'd0;
                    result_reg.bucket_sum <= cur_sum;
                    result_reg.grand_sum <= grand_reg;
                end
                if (have_free_reg && !found_reg && !cnt_ok_reg[bucket])
                    cnt_ok_reg[bucket] <= 1'b1;
            end
            if (cmd.clr_done)
                result_reg <= '{outcome: vmht_pkg::OUT_CLEARED, default: '0};
        end
    end

    assign done = done_reg;
    assign result = result_reg;

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mod_step, cmd.clr_step, cmd.rd, cmd.scan,
                  cmd.commit, cmd.clr_done}))
        else $error("overlapping commands");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.clr_done) |=> done_reg)
        else $error("result strobe missing");
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_done |=> grand_reg == 32'd0)
        else $error("grand sum not cleared");

endmodule

// ----- rtl/core/value_multiplicity_hash_table.sv -----
// Top level of the value multiplicity hash table.
// An enter transfer runs from the accepting edge to the edge that takes its result
// through the bit-serial modulo, a read and a scan for each slot of the bucket, one
// write-back and the strobe cycle. A clear zeroes one bucket sum a cycle. busy stays
// high meanwhile and drops in the strobe cycle, so the next item can be taken at
// the edge that takes the result; the result strobe 'done' lasts one cycle and
// cannot be stalled. A bucket left untouched since a clear reads as empty through
// a per-bucket valid bit.
module value_multiplicity_hash_table #(
    parameter int MAX_BUCKETS      = 256,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vmht_pkg::item_t   item,
    output logic              done,
    output vmht_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_data
);

    logic [8:0] hash_size_reg;
    vmht_pkg::cmd_t  cmd;
    vmht_pkg::stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_size_reg <= 9'd256;
        else if (cfg_we)
            hash_size_reg <= cfg_data;
    end

    vmht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    vmht_dp #(
        .MAX_BUCKETS      (MAX_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .hash_size (hash_size_reg),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule
